[rtl/dat_pkg.sv]
// shared types and constants for the digital audio transmitter register block
`timescale 1ns / 1ps
`default_nettype none
package dat_pkg;
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_STATUS   = 3'd1;
    localparam logic [2:0] REG_NONAUDIO = 3'd2;
    localparam logic [2:0] REG_DATA_A   = 3'd3;
    localparam logic [2:0] REG_DATA_B   = 3'd4;
    localparam logic [2:0] REG_PDATA    = 3'd5;
    localparam logic [2:0] REG_PDIR     = 3'd6;
    localparam logic [2:0] REG_PCTRL    = 3'd7;

    localparam logic [1:0] IRQ_UNDERRUN = 2'd0;
    localparam logic [1:0] IRQ_BLOCK    = 2'd1;
    localparam logic [1:0] IRQ_EMPTY    = 2'd2;

    localparam logic CFG_CORE = 1'b0;
    localparam logic CFG_ACI  = 1'b1;

    localparam logic [31:0] IDLE_CYCLES = 32'hFFFF_FFFF;

    // controller -> datapath commands
    typedef struct packed {
        logic do_step;   // apply the captured transaction
        logic div_start; // begin the core / rate division
        logic div_step;  // one iteration of the divider
        logic out_load;  // latch result into output registers
    } dat_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic need_div;  // last step changed period inputs
        logic div_last;  // divider at its final bit
    } dat_sts_t;
endpackage
`default_nettype wire

[rtl/dat_ctrl.sv]
// controller state machine for the transmitter register block
`timescale 1ns / 1ps
`default_nettype none
module dat_ctrl
    import dat_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire logic     m_ready,
    output logic          m_valid,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  dat_sts_t      sts,
    output dat_cmd_t      cmd
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_STEP  = 3'd1;
    localparam logic [2:0] ST_OUT   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       mv_reg, mv_next;
    logic       pend_reg, pend_next; // pending result from an item (vs config)

    // out register is free when empty or being taken
    logic out_free;
    assign out_free = !mv_reg || m_ready;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !s_valid;
    assign m_valid   = mv_reg;

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = ST_STEP;
                    pend_next  = 1'b1;
                end else if (cfg_valid && cfg_ready) begin
                    state_next = ST_STEP;
                    pend_next  = 1'b0;
                end
            end
            ST_STEP: begin
                cmd.do_step = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (sts.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else if (!pend_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    if (!pend_reg) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        cmd.out_load = 1'b1;
                        mv_next      = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            pend_reg  <= pend_next;
        end
    end
endmodule
`default_nettype wire

[rtl/dat_datapath.sv]
// register file, frame timer and period divider for the transmitter block
`timescale 1ns / 1ps
`default_nettype none
module dat_datapath
    import dat_pkg::*;
#(
    parameter int FRAMES_IN_BLOCK = 192
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_accept,
    input  wire logic [1:0]  s_operation,
    input  wire logic [2:0]  s_reg_index,
    input  wire logic [23:0] s_write_value,
    input  wire logic [15:0] s_elapsed_cycles,
    input  wire logic        cfg_accept,
    input  wire logic        cfg_index,
    input  wire logic        cfg_known,
    input  wire logic [31:0] cfg_data,
    input  dat_cmd_t         cmd,
    output dat_sts_t         sts,
    output logic [23:0]      m_read_value,
    output logic             m_frame_valid,
    output logic [23:0]      m_left_sample,
    output logic [23:0]      m_right_sample,
    output logic [23:0]      m_nonaudio_bits,
    output logic             m_retransmitted,
    output logic             m_irq_valid,
    output logic [1:0]       m_irq_kind,
    output logic [31:0]      m_cycles_to_next
);
    localparam logic [7:0] FRAMES = 8'(FRAMES_IN_BLOCK);

    // captured transaction
    logic        is_cfg_reg;
    logic        cfg_idx_reg, cfg_ok_reg;
    logic [31:0] cfg_val_reg;
    logic [1:0]  op_reg;
    logic [2:0]  idx_reg;
    logic [23:0] val_reg;
    logic [15:0] cyc_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            is_cfg_reg <= 1'b0;
            op_reg     <= s_operation;
            idx_reg    <= s_reg_index;
            val_reg    <= s_write_value;
            cyc_reg    <= s_elapsed_cycles;
        end else if (cfg_accept) begin
            is_cfg_reg  <= 1'b1;
            cfg_idx_reg <= cfg_index;
            cfg_ok_reg  <= cfg_known;
            cfg_val_reg <= cfg_data;
        end
    end

    // architectural state
    logic [31:0] core_reg, aci_reg;
    logic [5:0]  ctrl_reg;
    logic [2:0]  stat_reg;
    logic [23:0] nona_reg, cha_reg, chb_reg;
    logic        bnext_reg, armed_reg, pins_reg;
    logic [7:0]  fnum_reg;
    logic [31:0] since_reg, period_reg;
    logic [1:0]  pdata_reg, pdir_reg, pctrl_reg;
    logic        needdiv_reg;

    // result computed by the step
    logic [23:0] r_read;
    logic        r_fv, r_retx, r_irq;
    logic [1:0]  r_kind;
    logic [31:0] r_ctn;

    // next-state of one step
    logic [31:0] core_n, aci_n, since_n;
    logic [5:0]  ctrl_n;
    logic [2:0]  stat_n;
    logic [23:0] nona_n, cha_n, chb_n;
    logic        bnext_n, armed_n, pins_n, needdiv_n;
    logic [7:0]  fnum_n;
    logic [1:0]  pdata_n, pdir_n, pctrl_n;
    logic [23:0] r_read_n;
    logic        r_fv_n, r_retx_n, r_irq_n;
    logic [1:0]  r_kind_n;
    logic [31:0] r_ctn_n;
    logic [32:0] sum;
    logic [31:0] acc;
    logic [31:0] rem;
    logic        on;
    logic [8:0]  fplus;

    always_comb begin
        core_n = core_reg; aci_n = aci_reg; since_n = since_reg;
        ctrl_n = ctrl_reg; stat_n = stat_reg; nona_n = nona_reg;
        cha_n = cha_reg; chb_n = chb_reg; bnext_n = bnext_reg;
        armed_n = armed_reg; pins_n = pins_reg; fnum_n = fnum_reg;
        pdata_n = pdata_reg; pdir_n = pdir_reg; pctrl_n = pctrl_reg;
        needdiv_n = 1'b0;
        r_read_n = '0; r_fv_n = 1'b0; r_retx_n = 1'b0; r_irq_n = 1'b0;
        r_kind_n = IRQ_UNDERRUN; r_ctn_n = '0;
        sum = '0; acc = '0; rem = '0; on = 1'b0; fplus = '0;
        if (is_cfg_reg) begin
            if (cfg_ok_reg) begin
                if (cfg_idx_reg == CFG_CORE) core_n = cfg_val_reg;
                else aci_n = cfg_val_reg;
                needdiv_n = 1'b1;
            end
        end else if (op_reg == OP_READ) begin
            unique case (idx_reg)
                REG_CTRL:   r_read_n = {18'd0, ctrl_reg};
                REG_STATUS: r_read_n = {21'd0, stat_reg};
                REG_PDATA:  r_read_n = {22'd0, pdata_reg};
                REG_PDIR:   r_read_n = {22'd0, pdir_reg};
                REG_PCTRL:  r_read_n = {22'd0, pctrl_reg};
                default:    r_read_n = '0;
            endcase
        end else if (op_reg == OP_WRITE) begin
            unique case (idx_reg)
                REG_CTRL: begin
                    ctrl_n    = val_reg[5:0];
                    needdiv_n = 1'b1;
                end
                REG_NONAUDIO: nona_n = val_reg;
                REG_DATA_A, REG_DATA_B: begin
                    if (bnext_reg) begin
                        chb_n   = val_reg;
                        armed_n = 1'b1;
                        stat_n  = 3'b000;
                    end else begin
                        cha_n = val_reg;
                    end
                    bnext_n = !bnext_reg;
                end
                REG_PDATA: pdata_n = val_reg[1:0];
                REG_PDIR:  pdir_n  = val_reg[1:0];
                REG_PCTRL: pctrl_n = val_reg[1:0];
                default: ;
            endcase
            on = |(pctrl_n & pdir_n);
            if (on != pins_reg) begin
                pins_n = on;
                if (!on) begin
                    ctrl_n = '0; stat_n = '0; cha_n = '0; chb_n = '0;
                    bnext_n = 1'b0; armed_n = 1'b0; fnum_n = '0; since_n = '0;
                    needdiv_n = 1'b1;
                end else begin
                    fnum_n = '0; since_n = '0;
                end
            end
        end else if (op_reg == OP_TICK) begin
            sum = {1'b0, since_reg} + {17'd0, cyc_reg};
            acc = sum[32] ? IDLE_CYCLES : sum[31:0];
            since_n = acc;
            if (!pins_reg || period_reg == '0) begin
                r_ctn_n = IDLE_CYCLES;
            end else if (acc < period_reg) begin
                r_ctn_n = period_reg - acc;
            end else begin
                rem     = acc - period_reg;
                since_n = (rem >= period_reg) ? '0 : rem;
                if (ctrl_reg[5]) begin
                    ctrl_n = {1'b0, ctrl_reg[4:0]};
                    fnum_n = '0;
                end
                r_fv_n = 1'b1;
                if (armed_reg) armed_n = 1'b0;
                else begin
                    stat_n[1] = 1'b1;
                    r_retx_n  = 1'b1;
                end
                stat_n[0] = 1'b1;
                fplus = {1'b0, fnum_n} + 9'd1;
                if (fplus >= {1'b0, FRAMES}) stat_n[2] = 1'b1;
                if (stat_n[1] && ctrl_n[1]) begin
                    r_irq_n = 1'b1; r_kind_n = IRQ_UNDERRUN;
                end else if (stat_n[2] && ctrl_n[2]) begin
                    r_irq_n = 1'b1; r_kind_n = IRQ_BLOCK;
                end else if (ctrl_n[0]) begin
                    r_irq_n = 1'b1; r_kind_n = IRQ_EMPTY;
                end
                fnum_n = (fplus[7:0] >= FRAMES) ? 8'd0 : fplus[7:0];
                r_ctn_n = period_reg;
            end
        end
    end

    // restoring divider for core / rate; the rate itself comes from shifts
    // and, for the 384 divisor, a multiply by the reciprocal of three
    logic [31:0] dvd_reg, dvs_reg, q_reg;
    logic [32:0] r_reg;
    logic [4:0]  cnt_reg;
    logic [1:0]  sel;
    logic [56:0] third;
    logic [31:0] rate;
    logic [32:0] rsh, rdiff;

    assign sel = ctrl_reg[4:3];
    // aci / 384 is (aci / 128) / 3
    assign third = {32'd0, aci_reg[31:7]} * {25'd0, 32'hAAAA_AAAB};
    always_comb begin
        unique case (sel)
            2'd0:    rate = {10'd0, core_reg[31:10]};
            2'd1:    rate = {8'd0, aci_reg[31:8]};
            2'd2:    rate = {8'd0, third[56:33]};
            default: rate = {9'd0, aci_reg[31:9]};
        endcase
        rsh   = {r_reg[31:0], dvd_reg[31]};
        rdiff = rsh - {1'b0, dvs_reg};
    end

    assign sts.need_div = needdiv_reg;
    assign sts.div_last = (cnt_reg == 5'd31);

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dvd_reg <= core_reg;
            dvs_reg <= rate;
            r_reg   <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            cnt_reg <= cnt_reg + 5'd1;
            if (!rdiff[32]) begin
                r_reg <= rdiff;
                q_reg <= {q_reg[30:0], 1'b1};
            end else begin
                r_reg <= rsh;
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            core_reg <= '0; aci_reg <= '0; ctrl_reg <= '0; stat_reg <= '0;
            nona_reg <= '0; cha_reg <= '0; chb_reg <= '0; bnext_reg <= 1'b0;
            armed_reg <= 1'b0; pins_reg <= 1'b0; fnum_reg <= '0;
            since_reg <= '0; period_reg <= '0; pdata_reg <= '0;
            pdir_reg <= '0; pctrl_reg <= '0; needdiv_reg <= 1'b0;
        end else begin
            if (cmd.do_step) begin
                core_reg <= core_n; aci_reg <= aci_n; ctrl_reg <= ctrl_n;
                stat_reg <= stat_n; nona_reg <= nona_n; cha_reg <= cha_n;
                chb_reg <= chb_n; bnext_reg <= bnext_n; armed_reg <= armed_n;
                pins_reg <= pins_n; fnum_reg <= fnum_n; since_reg <= since_n;
                pdata_reg <= pdata_n; pdir_reg <= pdir_n; pctrl_reg <= pctrl_n;
                needdiv_reg <= needdiv_n;
            end
            // period lands with the last bit; zero rate gives zero period
            if (cmd.div_step && sts.div_last) begin
                period_reg <= (dvs_reg == '0) ? 32'd0
                            : {q_reg[30:0], !rdiff[32]};
            end
        end
    end

    // frame words are taken from the registers after the step (ticks never change them)
    logic [23:0] cha_reg_s, chb_reg_s;
    assign cha_reg_s = cha_reg;
    assign chb_reg_s = chb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.do_step) begin
            r_read <= r_read_n; r_fv <= r_fv_n; r_retx <= r_retx_n;
            r_irq <= r_irq_n; r_kind <= r_kind_n; r_ctn <= r_ctn_n;
        end
        if (cmd.out_load) begin
            m_read_value     <= r_read;
            m_frame_valid    <= r_fv;
            m_left_sample    <= r_fv ? cha_reg_s : 24'd0;
            m_right_sample   <= r_fv ? chb_reg_s : 24'd0;
            m_nonaudio_bits  <= r_fv ? nona_reg : 24'd0;
            m_retransmitted  <= r_retx;
            m_irq_valid      <= r_irq;
            m_irq_kind       <= r_kind;
            m_cycles_to_next <= r_ctn;
        end
    end
endmodule
`default_nettype wire

[rtl/digital_audio_transmitter_regs.sv]
// top level of the digital audio transmitter register block
`timescale 1ns / 1ps
`default_nettype none
// Register model of an S/PDIF-style transmitter. Each input transaction is a
// bus read, a bus write or a time tick, and gives exactly one result
// transaction. A read, a tick or most writes pass through the step and output
// load states after acceptance, and the next transaction is taken once the
// block is back in idle. A control write, a port write that turns the
// transmitter off, or a clock configuration write also recomputes the frame
// period: the sample rate comes from shifts and a reciprocal multiply, then a
// restoring divider forms core/rate in 32 iterations, and an item's result
// is loaded after that. One transaction is in flight at a time; while a
// result waits on the output, the next transaction is still accepted and its
// result is held inside until the output register frees. Configuration
// writes are taken only when the block is idle.
module digital_audio_transmitter_regs
    import dat_pkg::*;
#(
    parameter int FRAMES_IN_BLOCK = 192
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // item channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [2:0]  s_reg_index,
    input  wire logic [23:0] s_write_value,
    input  wire logic [15:0] s_elapsed_cycles,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [23:0]      m_read_value,
    output logic             m_frame_valid,
    output logic [23:0]      m_left_sample,
    output logic [23:0]      m_right_sample,
    output logic [23:0]      m_nonaudio_bits,
    output logic             m_retransmitted,
    output logic             m_irq_valid,
    output logic [1:0]       m_irq_kind,
    output logic [31:0]      m_cycles_to_next,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_index,
    input  wire logic [31:0] cfg_data
);
    dat_cmd_t cmd;
    dat_sts_t sts;
    logic     s_accept, cfg_accept, cfg_known;

    assign s_accept   = s_valid && s_ready;
    assign cfg_accept = cfg_valid && cfg_ready;
    // only index 0 (core clock) and index 1 (ACI clock) exist; others are ignored
    assign cfg_known  = (cfg_index[31:1] == '0);

    dat_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_ready, .m_valid,
        .cfg_valid, .cfg_ready, .sts, .cmd
    );

    dat_datapath #(.FRAMES_IN_BLOCK(FRAMES_IN_BLOCK)) u_dp (
        .aclk, .aresetn, .s_accept, .s_operation, .s_reg_index,
        .s_write_value, .s_elapsed_cycles, .cfg_accept,
        .cfg_index(cfg_index[0]), .cfg_known, .cfg_data, .cmd, .sts,
        .m_read_value, .m_frame_valid, .m_left_sample, .m_right_sample,
        .m_nonaudio_bits, .m_retransmitted, .m_irq_valid, .m_irq_kind,
        .m_cycles_to_next
    );
endmodule
`default_nettype wire

[rtl/dat_checker.sv]
// port checker for the transmitter block and its bind
`timescale 1ns / 1ps
`default_nettype none
module dat_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_frame_valid,
    input wire logic        m_irq_valid,
    input wire logic [1:0]  m_irq_kind,
    input wire logic [23:0] m_read_value
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid) else $error("input withdrawn");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_irq_valid |-> m_frame_valid) else $error("irq without frame");
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_irq_valid |-> m_irq_kind != 2'd3) else $error("bad irq kind");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_valid |-> m_read_value == 24'd0)
        else $error("read data on frame");
endmodule

bind digital_audio_transmitter_regs dat_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_frame_valid, .m_irq_valid, .m_irq_kind, .m_read_value
);
`default_nettype wire
